// ===== rtl/core/integer_to_roman_encoder_unit_assert.svh =====
// Assertion macros for the Roman numeral encoder.
// Included by the top level; simulation-only checks, empty under synthesis.
`ifndef INTEGER_TO_ROMAN_ENCODER_UNIT_ASSERT_SVH
`define INTEGER_TO_ROMAN_ENCODER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define I2R_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2r assertion failed");
// Next-cycle implication, disabled while reset is asserted
`define I2R_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2r assertion failed");
`else
`define I2R_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define I2R_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/i2r_pkg.sv =====
// Shared types, constants and the greedy step table of the Roman numeral encoder.
// No dependencies; used by i2r_ctrl, i2r_dp and the top level.
`default_nettype none
package i2r_pkg;

    localparam int unsigned ValueW   = 12;
    localparam int unsigned CharW    = 7;
    localparam int unsigned WeightW  = 10;
    localparam int unsigned NumSteps = 13;
    localparam logic [ValueW-1:0] ValueLimit = 12'd4000;

    localparam logic [CharW-1:0] CH_NONE = 7'd0;
    localparam logic [CharW-1:0] CH_M = 7'h4D;
    localparam logic [CharW-1:0] CH_D = 7'h44;
    localparam logic [CharW-1:0] CH_C = 7'h43;
    localparam logic [CharW-1:0] CH_L = 7'h4C;
    localparam logic [CharW-1:0] CH_X = 7'h58;
    localparam logic [CharW-1:0] CH_V = 7'h56;
    localparam logic [CharW-1:0] CH_I = 7'h49;

    // One greedy step: weight, leading symbol, optional trailing symbol
    typedef struct packed {
        logic [WeightW-1:0] weight;
        logic [CharW-1:0]   first;
        logic [CharW-1:0]   second;
    } step_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic emit;
    } i2r_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
        logic last;
    } i2r_stat_t;

    localparam step_t StepTable [NumSteps] = '{
        '{10'd1000, CH_M, CH_NONE},
        '{10'd900,  CH_C, CH_M},
        '{10'd500,  CH_D, CH_NONE},
        '{10'd400,  CH_C, CH_D},
        '{10'd100,  CH_C, CH_NONE},
        '{10'd90,   CH_X, CH_C},
        '{10'd50,   CH_L, CH_NONE},
        '{10'd40,   CH_X, CH_L},
        '{10'd10,   CH_X, CH_NONE},
        '{10'd9,    CH_I, CH_X},
        '{10'd5,    CH_V, CH_NONE},
        '{10'd4,    CH_I, CH_V},
        '{10'd1,    CH_I, CH_NONE}
    };

    // Pick the largest step whose weight fits in the remainder (parallel compares)
    function automatic step_t step_pick(input logic [ValueW-1:0] rest);
        step_t sel;
        sel = StepTable[NumSteps-1];
        for (int k = NumSteps - 1; k >= 0; k--) begin
            if (rest >= {{(ValueW-WeightW){1'b0}}, StepTable[k].weight}) begin
                sel = StepTable[k];
            end
        end
        return sel;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/i2r_ctrl.sv =====
// Controller of the Roman numeral encoder: sequences load and symbol emission.
// Depends on i2r_pkg for the command and status structs.
`default_nettype none
module i2r_ctrl import i2r_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  i2r_stat_t      stat,
    output i2r_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } i2r_state_t;

    i2r_state_t state_reg, state_next;

    // Decode commands and next state
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/i2r_dp.sv =====
// Datapath of the Roman numeral encoder: remainder, pending symbol, output register.
// Depends on i2r_pkg for the step table and the command and status structs.
`default_nettype none
module i2r_dp import i2r_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [15:0]  s_tdata,
    input  i2r_cmd_t          cmd,
    output i2r_stat_t         stat,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,
    output logic              m_tlast,
    output logic [0:0]        m_tuser
);

    logic [ValueW-1:0] rest_reg, rest_next;
    logic [CharW-1:0]  pend_reg, pend_next;
    logic              bad_reg;
    logic              valid_reg;
    logic [CharW-1:0]  char_reg;
    logic              last_reg;
    logic              inv_reg;

    logic [ValueW-1:0] in_value;
    step_t             step;
    logic [CharW-1:0]  emit_char;
    logic              emit_last;

    assign in_value = s_tdata[ValueW-1:0];
    assign step     = step_pick(rest_reg);

    // Choose the symbol of this beat and the remainder it leaves
    always_comb begin
        rest_next = rest_reg;
        pend_next = pend_reg;
        emit_char = CH_NONE;
        emit_last = 1'b1;
        if (bad_reg) begin
            emit_char = CH_NONE;
            emit_last = 1'b1;
        end else if (pend_reg != CH_NONE) begin
            emit_char = pend_reg;
            pend_next = CH_NONE;
            emit_last = (rest_reg == '0);
        end else begin
            emit_char = step.first;
            pend_next = step.second;
            rest_next = rest_reg - {{(ValueW-WeightW){1'b0}}, step.weight};
            emit_last = (step.second == CH_NONE) && (rest_next == '0);
        end
    end

    assign stat.out_free = !valid_reg || m_tready;
    assign stat.last     = emit_last;

    // Load a new value or advance by one symbol
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rest_reg <= in_value;
            pend_reg <= CH_NONE;
            bad_reg  <= (in_value == '0) || (in_value >= ValueLimit);
        end else if (cmd.emit) begin
            rest_reg <= rest_next;
            pend_reg <= pend_next;
        end
    end

    // Output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            char_reg <= emit_char;
            last_reg <= emit_last;
            inv_reg  <= bad_reg;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = inv_reg;

endmodule
`default_nettype wire

// ===== rtl/core/integer_to_roman_encoder_unit.sv =====
// Roman numeral encoder, top level.
// Input: s_tvalid/s_tready/s_tdata carry one 12-bit value per beat.
// Output: m_tvalid/m_tready/m_tdata/m_tlast/m_tuser carry one ASCII symbol per
// beat in writing order; m_tlast marks the final symbol of a number.
// Values 0 and 4000..4095 give one beat with char 0, m_tlast and m_tuser set.
// An accepted value is loaded first; the output beat register then takes its first symbol.
// Throughput: a number has 1 to 15 symbols, emitted by the emit loop at one symbol
// per cycle while the receiver does not stall, after the value is loaded in idle.
// One number is converted at a time; s_tready is high only between numbers,
// and a new value may be taken while the final symbol still waits at the output.
// A stalled receiver (m_tready low) holds the output beat and pauses emission.
// Reset (aresetn low, synchronous) drops any beat in flight and returns to idle.
// Depends on i2r_pkg, i2r_ctrl, i2r_dp and the assertion macro header.
`default_nettype none
`include "integer_to_roman_encoder_unit_assert.svh"
module integer_to_roman_encoder_unit import i2r_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [6:0] symbol_char
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // [0] invalid
);

    i2r_cmd_t  cmd;
    i2r_stat_t stat;

    i2r_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    i2r_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // An invalid beat is a lone beat with no symbol
    `I2R_ASSERT_NOW(a_inv_single, aclk, aresetn, m_tvalid && m_tuser[0], m_tlast && (m_tdata[6:0] == CH_NONE))
    // A valid numeral beat always carries a symbol
    `I2R_ASSERT_NOW(a_sym_nonzero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[6:0] != CH_NONE)
    // After taking a value, input is held off (s_tready drops)
    `I2R_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for integer_to_roman_encoder_unit: streams 12-bit values in and checks each
// ASCII symbol beat against a greedy Roman numeral predictor. Depends on i2r_pkg and the RTL.
module tb;
    import i2r_pkg::*;

    localparam int unsigned CycleLimit   = 3000000;
    localparam int unsigned RandomValues = 500;
    localparam int unsigned TailCycles   = 20;

    // One expected symbol beat
    typedef struct packed {
        logic [CharW-1:0] symbol;
        logic             last;
        logic             invalid;
    } roman_beat_t;

    // One value waiting to be sent; drain holds it back until all symbols are out
    typedef struct packed {
        logic [ValueW-1:0] value;
        logic              drain;
    } value_req_t;

    // Greedy table, largest weight first, with subtractive pairs
    localparam int unsigned NumPairs = 13;
    localparam int unsigned PairWeight [NumPairs] = '{
        1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1
    };
    localparam logic [CharW-1:0] PairLead [NumPairs] = '{
        CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I
    };
    localparam logic [CharW-1:0] PairTrail [NumPairs] = '{
        CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L,
        CH_NONE, CH_X, CH_NONE, CH_V, CH_NONE
    };

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic [0:0]  m_tuser;

    value_req_t  pending_values [$];
    roman_beat_t expected_symbols [$];
    value_req_t  next_req;
    int unsigned values_sent   = 0;
    int unsigned symbols_seen  = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_gap      = 0;
    int unsigned stall_left    = 0;
    bit          calm          = 1'b0;

    integer_to_roman_encoder_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, a few long ones; none during calm stretches
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Spell one value as Roman symbols and queue the expected beats
    task automatic spell_roman(input logic [ValueW-1:0] value);
        int unsigned      rest;
        logic [CharW-1:0] syms [$];
        roman_beat_t      beat;
        rest = value;
        if (value == '0 || value >= ValueLimit) begin
            beat = '{symbol: CH_NONE, last: 1'b1, invalid: 1'b1};
            expected_symbols.push_back(beat);
        end else begin
            for (int i = 0; i < NumPairs; i++) begin
                while (rest >= PairWeight[i]) begin
                    syms.push_back(PairLead[i]);
                    if (PairTrail[i] != CH_NONE) syms.push_back(PairTrail[i]);
                    rest -= PairWeight[i];
                end
            end
            for (int k = 0; k < syms.size(); k++) begin
                beat = '{symbol: syms[k], last: (k == syms.size() - 1), invalid: 1'b0};
                expected_symbols.push_back(beat);
            end
        end
    endtask

    // Driver: predict on each accepted beat, then present the next value or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'd0;
        end else begin
            if (s_tvalid && s_tready) begin
                spell_roman(s_tdata[ValueW-1:0]);
                values_sent++;
                if (values_sent % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_values.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_values[0].drain && expected_symbols.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    next_req = pending_values.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'd0, next_req.value};
                    send_gap = draw_gap();
                end
            end
        end
    end

    // Monitor: compare each accepted symbol beat with the oldest expectation
    always @(posedge aclk) begin
        roman_beat_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                symbols_seen++;
                if (expected_symbols.size() == 0) begin
                    $error("unexpected symbol beat: symbol_char=%h last=%b invalid=%b",
                           m_tdata[CharW-1:0], m_tlast, m_tuser[0]);
                    error_count++;
                end else begin
                    want = expected_symbols.pop_front();
                    if (m_tdata[CharW-1:0] !== want.symbol) begin
                        $error("symbol_char: expected %h, got %h", want.symbol,
                               m_tdata[CharW-1:0]);
                        error_count++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_tlast);
                        error_count++;
                    end
                    if (m_tuser[0] !== want.invalid) begin
                        $error("invalid: expected %b, got %b", want.invalid, m_tuser[0]);
                        error_count++;
                    end
                end
            end
            // Random receiver stalls
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = draw_gap();
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("integer_to_roman_encoder_unit verification failed");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        logic [ValueW-1:0] directed [$];
        value_req_t        req;
        logic [ValueW-1:0] v;
        int unsigned       r;

        // Extremes, every subtractive pair, longest numeral, invalid values
        directed = '{12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd0, 12'd3888, 12'd3888,
                     12'd4, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900, 12'd5, 12'd50,
                     12'd500, 12'd1000, 12'd2048, 12'd1444, 12'd3, 12'd3494, 12'd2730,
                     12'd1365};
        foreach (directed[i]) begin
            req = '{value: directed[i], drain: 1'b0};
            pending_values.push_back(req);
        end

        for (int n = 0; n < RandomValues; n++) begin
            r = $urandom_range(0, 99);
            if (r < 55) v = 12'($urandom_range(1, 3999));
            else if (r < 75) v = 12'($urandom_range(1, 99));
            else if (r < 85) v = (r < 80) ? 12'd0 : 12'($urandom_range(4000, 4095));
            else v = 12'($urandom_range(0, 4095));
            // Let the output drain completely now and then
            req = '{value: v, drain: (n == 0 || n == RandomValues / 2)};
            pending_values.push_back(req);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_values.size() != 0 || s_tvalid || expected_symbols.size() != 0)
            @(posedge aclk);
        repeat (TailCycles) @(posedge aclk);

        if (expected_symbols.size() != 0) begin
            $error("%0d expected symbol beats never arrived", expected_symbols.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("integer_to_roman_encoder_unit verification clean");
        end else begin
            $display("integer_to_roman_encoder_unit verification failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/i2r_pkg.sv
rtl/core/i2r_ctrl.sv
rtl/core/i2r_dp.sv
rtl/core/integer_to_roman_encoder_unit.sv
dv/tb.sv
